/* sv/delta_modulation_sample_channel_top_assert.svh */
// Assertion macros for the delta-modulation sample channel checker.
// Expects signals clk and arst_n in the scope of each use.
`ifndef DELTA_MODULATION_SAMPLE_CHANNEL_TOP_ASSERT_SVH
`define DELTA_MODULATION_SAMPLE_CHANNEL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DMSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dmsc_pkg.sv */
// Shared types, codes and tables of the delta-modulation sample channel.
// No dependencies.
`timescale 1ns / 1ps

package dmsc_pkg;

	// request kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_START = 2'd3;

	// register indexes
	localparam logic [1:0] REG_FLAGS  = 2'd0;
	localparam logic [1:0] REG_LEVEL  = 2'd1;
	localparam logic [1:0] REG_ADDR   = 2'd2;
	localparam logic [1:0] REG_LENGTH = 2'd3;

	localparam logic [15:0] ADDR_BASE = 16'hC000;
	localparam logic [15:0] ADDR_WRAP = 16'h8000;

	localparam logic [6:0] LEVEL_STEP    = 7'd2;
	localparam logic [6:0] LEVEL_INC_MAX = 7'd125;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// timer period per rate index, in ticks minus one
	localparam logic [8:0] PERIOD [16] = '{
		9'h1AC, 9'h17C, 9'h154, 9'h140, 9'h11E, 9'h0FE, 9'h0E2, 9'h0D6,
		9'h0BE, 9'h0A0, 9'h08E, 9'h080, 9'h06A, 9'h054, 9'h048, 9'h036
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] reg_index;
		logic [7:0] write_value;
		logic [7:0] read_data;
	} item_t;

	typedef struct packed {
		logic [6:0]  level_out;
		logic        irq_pending;
		logic        fetch_request;
		logic [15:0] fetch_address;
		logic        is_playing;
	} result_t;

	typedef struct packed {
		logic       irq_en;
		logic       loop_enable;
		logic [7:0] start_block;
		logic [7:0] length_blocks;
	} fetch_cfg_t;

	typedef struct packed {
		logic       tick;
		logic       load_byte;
		logic       start;
		logic       irq_clear;
		logic       take;
		logic [7:0] data;
	} fetch_cmd_t;

	typedef struct packed {
		logic        buf_full;
		logic [7:0]  buf_byte;
		logic        req;
		logic [15:0] addr;
		logic        playing;
		logic        irq;
	} fetch_stat_t;

endpackage

/* sv/dmsc_stream_if.sv */
// Valid/ready stream channel carrying one payload of type data_t.
// Depends on nothing; payload types come from dmsc_pkg at instantiation.
`timescale 1ns / 1ps

interface dmsc_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/dmsc_fetch.sv */
// Byte-fetch sequencer and one-byte sample buffer of the channel.
// Depends on dmsc_pkg.
`timescale 1ns / 1ps

module dmsc_fetch (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dmsc_pkg::fetch_cfg_t cfg,
	input  dmsc_pkg::fetch_cmd_t cmd,
	output dmsc_pkg::fetch_stat_t stat
);

	logic        get_q, pend_q, empty_q, playing_q, start_q, irq_q;
	logic [7:0]  fetched_q, buf_q;
	logic [11:0] off_q, left_q;

	logic        n_get, n_pend, n_empty, n_playing, n_start, n_irq;
	logic [7:0]  n_fetched, n_buf;
	logic [11:0] n_off, n_left;
	logic [11:0] sample_len;
	logic [15:0] addr_sum, fetch_addr;
	logic        req;

	// length_blocks * 16 + 1
	assign sample_len = {cfg.length_blocks, 4'b0001};
	assign addr_sum   = dmsc_pkg::ADDR_BASE + {2'b00, cfg.start_block, 6'b000000}
		+ {4'b0000, off_q};
	assign fetch_addr = (addr_sum < dmsc_pkg::ADDR_BASE) ?
		addr_sum + dmsc_pkg::ADDR_WRAP : addr_sum;

	always_comb begin
		n_get     = get_q;
		n_pend    = pend_q;
		n_empty   = empty_q;
		n_playing = playing_q;
		n_start   = start_q;
		n_irq     = irq_q;
		n_fetched = fetched_q;
		n_buf     = buf_q;
		n_off     = off_q;
		n_left    = left_q;
		req       = 1'b0;
		if (cmd.tick) begin
			n_get = ~get_q;
			if (left_q != 12'd0 && playing_q) begin
				if (empty_q) begin
					if (get_q && !pend_q) begin
						n_pend = 1'b1;
						req    = 1'b1;
					end else if (!get_q && pend_q) begin
						n_buf   = fetched_q;
						n_empty = 1'b0;
						n_pend  = 1'b0;
						n_off   = off_q + 12'd1;
						n_left  = left_q - 12'd1;
					end
					// end of sample: loop back or flag the interrupt
					if (n_left == 12'd0) begin
						n_playing = 1'b0;
						if (cfg.loop_enable) begin
							n_left    = sample_len;
							n_off     = 12'd0;
							n_playing = 1'b1;
						end else if (cfg.irq_en) begin
							n_irq = 1'b1;
						end
						n_start = 1'b0;
					end
				end
			end else if (start_q) begin
				n_left    = sample_len;
				n_off     = 12'd0;
				n_playing = 1'b1;
			end
		end
		if (cmd.load_byte)
			n_fetched = cmd.data;
		if (cmd.start)
			n_start = 1'b1;
		if (cmd.irq_clear)
			n_irq = 1'b0;
	end

	assign stat.buf_full = ~n_empty;
	assign stat.buf_byte = n_buf;
	assign stat.req      = req;
	assign stat.addr     = req ? fetch_addr : 16'd0;
	assign stat.playing  = n_playing;
	assign stat.irq      = n_irq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			get_q     <= 1'b1;
			pend_q    <= 1'b0;
			empty_q   <= 1'b1;
			playing_q <= 1'b0;
			start_q   <= 1'b0;
			irq_q     <= 1'b0;
			fetched_q <= 8'd0;
			buf_q     <= 8'd0;
			off_q     <= 12'd0;
			left_q    <= 12'd0;
		end else begin
			get_q     <= n_get;
			pend_q    <= n_pend;
			empty_q   <= cmd.take ? 1'b1 : n_empty;
			playing_q <= n_playing;
			start_q   <= n_start;
			irq_q     <= n_irq;
			fetched_q <= n_fetched;
			buf_q     <= n_buf;
			off_q     <= n_off;
			left_q    <= n_left;
		end
	end

endmodule

/* sv/delta_modulation_sample_channel_top.sv */
// Delta-modulation sample channel: one request per CPU cycle tick, register
// write, read-data return or start, one result per request. Requests are
// taken at one per clock cycle sustained while the result side keeps up. A
// taken request waits in the request register until the result register is
// free or being emptied, is then processed, and its result is registered in
// the result register, which drives the result port until the result side
// takes it. While a result waits, the request register holds one more request
// and then the request side stalls. The whole state update of a request is
// combinational between the request register and the result register.
// Depends on dmsc_pkg, dmsc_stream_if and dmsc_fetch.
`timescale 1ns / 1ps

module delta_modulation_sample_channel_top (
	input logic clk,
	input logic arst_n,
	dmsc_stream_if.sink   req,
	dmsc_stream_if.source rsp
);

	// request register (stage 1) and result register (stage 2)
	dmsc_pkg::item_t   item_s1;
	logic              vld_s1;
	dmsc_pkg::result_t res_s2;
	logic              vld_s2;
	logic              advance;

	// channel registers
	logic       irq_en_q, loop_en_q;
	logic [3:0] rate_q;
	logic [7:0] start_block_q, length_blocks_q;
	logic [6:0] level_q;

	// output unit
	logic [8:0] timer_q;
	logic [7:0] shifter_q;
	logic [3:0] bits_q;
	logic       silent_q;

	logic       wr, tick;
	logic [8:0] timer_inc;
	logic       fire, reload;
	logic [3:0] bits_dec;
	logic [6:0] level_adj, n_level;

	dmsc_pkg::fetch_cfg_t  fcfg;
	dmsc_pkg::fetch_cmd_t  fcmd;
	dmsc_pkg::fetch_stat_t fstat;

	// Process the held request whenever the result register is free or
	// being emptied this cycle; take a new request whenever stage 1 is empty or moves on.
	assign advance   = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || advance;
	assign rsp.valid = vld_s2;
	assign rsp.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			item_s1 <= req.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	assign wr   = advance && item_s1.kind == dmsc_pkg::KIND_WRITE;
	assign tick = advance && item_s1.kind == dmsc_pkg::KIND_TICK;

	// Rate timer: fire once the incremented count passes the period, so
	// each output bit lasts period + 1 ticks.
	assign timer_inc = timer_q + 9'd1;
	assign fire      = timer_inc > dmsc_pkg::PERIOD[rate_q];
	assign bits_dec  = (bits_q != 4'd0) ? bits_q - 4'd1 : 4'd0;
	assign reload    = fire && bits_dec == 4'd0;

	// Step the level by two, holding it inside 0..127.
	always_comb begin
		level_adj = level_q;
		if (shifter_q[0]) begin
			if (level_q <= dmsc_pkg::LEVEL_INC_MAX)
				level_adj = level_q + dmsc_pkg::LEVEL_STEP;
		end else begin
			if (level_q >= dmsc_pkg::LEVEL_STEP)
				level_adj = level_q - dmsc_pkg::LEVEL_STEP;
		end
	end

	always_comb begin
		n_level = level_q;
		if (wr && item_s1.reg_index == dmsc_pkg::REG_LEVEL)
			n_level = item_s1.write_value[6:0];
		else if (tick && fire && !silent_q)
			n_level = level_adj;
	end

	// The fetch sequencer runs ahead of the output unit within a tick, so
	// the buffer it reports already holds any byte latched on this put cycle.
	assign fcfg.irq_en        = irq_en_q;
	assign fcfg.loop_enable   = loop_en_q;
	assign fcfg.start_block   = start_block_q;
	assign fcfg.length_blocks = length_blocks_q;

	assign fcmd.tick      = tick;
	assign fcmd.load_byte = advance && item_s1.kind == dmsc_pkg::KIND_READ;
	assign fcmd.start     = advance && item_s1.kind == dmsc_pkg::KIND_START;
	assign fcmd.irq_clear = wr && item_s1.reg_index == dmsc_pkg::REG_FLAGS
		&& !item_s1.write_value[7];
	assign fcmd.take      = tick && reload && fstat.buf_full;
	assign fcmd.data      = item_s1.read_data;

	dmsc_fetch u_fetch (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (fcfg),
		.cmd    (fcmd),
		.stat   (fstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q        <= 1'b0;
			loop_en_q       <= 1'b0;
			rate_q          <= 4'd0;
			start_block_q   <= 8'd0;
			length_blocks_q <= 8'd0;
			level_q         <= 7'd0;
			timer_q         <= 9'd0;
			shifter_q       <= 8'd0;
			bits_q          <= 4'd0;
			silent_q        <= 1'b1;
		end else begin
			level_q <= n_level;
			if (wr) begin
				case (item_s1.reg_index)
					dmsc_pkg::REG_FLAGS: begin
						irq_en_q  <= item_s1.write_value[7];
						loop_en_q <= item_s1.write_value[6];
						rate_q    <= item_s1.write_value[3:0];
					end
					dmsc_pkg::REG_ADDR:   start_block_q   <= item_s1.write_value;
					dmsc_pkg::REG_LENGTH: length_blocks_q <= item_s1.write_value;
					default: ;
				endcase
			end
			if (tick) begin
				timer_q <= fire ? 9'd0 : timer_inc;
				if (fire) begin
					// shift out one bit; after the eighth, reload from the buffer
					// or fall silent when it is empty
					if (reload && fstat.buf_full)
						shifter_q <= fstat.buf_byte;
					else
						shifter_q <= shifter_q >> 1;
					bits_q <= reload ? dmsc_pkg::BITS_PER_BYTE : bits_dec;
					if (reload)
						silent_q <= ~fstat.buf_full;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.level_out     <= n_level;
			res_s2.irq_pending   <= fstat.irq;
			res_s2.fetch_request <= fstat.req;
			res_s2.fetch_address <= fstat.addr;
			res_s2.is_playing    <= fstat.playing;
		end
	end

endmodule

/* sv/dmsc_checker.sv */
// Port-level checks on the result channel of the sample channel top level.
// Depends on dmsc_pkg and the assertion macro header; bound to the top level.
`timescale 1ns / 1ps
`include "delta_modulation_sample_channel_top_assert.svh"

module dmsc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input dmsc_pkg::result_t rsp_data
);

	`DMSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")
	`DMSC_ASSERT_NOW(a_addr_idle, rsp_valid && !rsp_data.fetch_request, rsp_data.fetch_address == 16'd0, "address shown without a fetch")
	`DMSC_ASSERT_NOW(a_addr_range, rsp_valid && rsp_data.fetch_request, rsp_data.fetch_address[15], "fetch address below the sample window")
	`DMSC_ASSERT_NOW(a_fetch_playing, rsp_valid && rsp_data.fetch_request, rsp_data.is_playing, "fetch issued while not playing")

endmodule

bind delta_modulation_sample_channel_top dmsc_checker u_dmsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
